// ----- sv/ped_pkg.sv -----
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types, constants and helpers for the percent-escape decoder.
// ----------------------------------------------------------------------------
package ped_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CTRL_MAX   = 8'd31;

  localparam int unsigned MAX_RES = 3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // Up to three result bytes caused by one input transaction
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [MAX_RES-1:0]      bad;
    logic [1:0]              count;
    logic                    last;
  } res_t;

  // Bit 4 set when the byte is a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ----- sv/ped_if.sv -----
// ----------------------------------------------------------------------------
// ped_in_if / ped_out_if
// Valid/ready channels for raw bytes in and decoded bytes out.
// ----------------------------------------------------------------------------
interface ped_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ped_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       bad_escape;
  logic       run_end;
  logic       span_end;

  modport source (output valid, output out_byte, output bad_escape,
                  output run_end, output span_end, input ready);
  modport sink   (input valid, input out_byte, input bad_escape,
                  input run_end, input span_end, output ready);
endinterface

// ----- sv/ped_decode.sv -----
// ----------------------------------------------------------------------------
// ped_decode
// Escape state tracking and per-byte decode into a bundle of up to three
// result bytes.
// ----------------------------------------------------------------------------
module ped_decode (
  input  logic          clk,
  input  logic          rst,
  ped_in_if.sink        in_ch,
  input  logic          space,
  output logic          fire,
  output ped_pkg::res_t res
);

  ped_pkg::phase_t phase;
  ped_pkg::phase_t phase_next;
  logic [7:0]      held_digit;
  logic [7:0]      held_digit_next;

  logic [4:0] hv;
  logic [4:0] hv_held;
  logic [7:0] val;
  logic       pct;
  logic       good_val;

  assign in_ch.ready = space;
  assign fire        = in_ch.valid & in_ch.ready;

  assign hv       = ped_pkg::hex_value(in_ch.in_byte);
  assign hv_held  = ped_pkg::hex_value(held_digit);
  assign val      = {hv_held[3:0], hv[3:0]};
  assign pct      = (in_ch.in_byte == ped_pkg::CHAR_PCT);
  assign good_val = (val > ped_pkg::CTRL_MAX) && (val != ped_pkg::CHAR_DEL) &&
                    (val != ped_pkg::CHAR_COLON);

  always_comb begin
    res             = '0;
    res.last        = in_ch.in_last;
    phase_next      = ped_pkg::PH_IDLE;
    held_digit_next = held_digit;
    case (phase)
      ped_pkg::PH_PCT: begin
        if (in_ch.in_last) begin
          res.bytes[0] = ped_pkg::CHAR_PCT;
          res.bytes[1] = in_ch.in_byte;
          res.bad      = 3'b011;
          res.count    = 2'd2;
        end else if (hv[4]) begin
          held_digit_next = in_ch.in_byte;
          phase_next      = ped_pkg::PH_DIGIT;
        end else if (pct) begin
          res.bytes[0] = ped_pkg::CHAR_PCT;
          res.bad      = 3'b001;
          res.count    = 2'd1;
          phase_next   = ped_pkg::PH_PCT;
        end else begin
          res.bytes[0] = ped_pkg::CHAR_PCT;
          res.bytes[1] = in_ch.in_byte;
          res.bad      = 3'b011;
          res.count    = 2'd2;
        end
      end
      ped_pkg::PH_DIGIT: begin
        if (hv[4]) begin
          if (good_val) begin
            res.bytes[0] = val;
            res.count    = 2'd1;
          end else begin
            res.bytes[0] = ped_pkg::CHAR_PCT;
            res.bytes[1] = held_digit;
            res.bytes[2] = in_ch.in_byte;
            res.count    = 2'd3;
          end
        end else if (pct && !in_ch.in_last) begin
          res.bytes[0] = ped_pkg::CHAR_PCT;
          res.bytes[1] = held_digit;
          res.bad      = 3'b011;
          res.count    = 2'd2;
          phase_next   = ped_pkg::PH_PCT;
        end else begin
          res.bytes[0] = ped_pkg::CHAR_PCT;
          res.bytes[1] = held_digit;
          res.bytes[2] = in_ch.in_byte;
          res.bad      = 3'b111;
          res.count    = 2'd3;
        end
      end
      default: begin
        if (pct) begin
          if (in_ch.in_last) begin
            res.bytes[0] = ped_pkg::CHAR_PCT;
            res.bad      = 3'b001;
            res.count    = 2'd1;
          end else begin
            phase_next = ped_pkg::PH_PCT;
          end
        end else begin
          res.bytes[0] = in_ch.in_byte;
          res.count    = 2'd1;
        end
      end
    endcase
    // end of span clears any pending escape
    if (in_ch.in_last) begin
      phase_next      = ped_pkg::PH_IDLE;
      held_digit_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ped_pkg::PH_IDLE;
      held_digit <= 8'd0;
    end else if (fire) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

// ----- sv/ped_emit.sv -----
// ----------------------------------------------------------------------------
// ped_emit
// Result register that holds one decoded bundle and hands its bytes out
// one transaction per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module ped_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  ped_pkg::res_t res,
  output logic          space,
  ped_out_if.source     out_ch
);

  logic [ped_pkg::MAX_RES-1:0][7:0] slot_byte;
  logic [ped_pkg::MAX_RES-1:0]      slot_bad;
  logic                             slot_last;
  logic [1:0]                       rem;
  logic [1:0]                       pos;
  logic                             take;

  assign take  = out_ch.valid & out_ch.ready;
  // accept when empty or while the final byte of the held bundle leaves this cycle
  assign space = (rem == 2'd0) || ((rem == 2'd1) && out_ch.ready);

  assign out_ch.valid      = (rem != 2'd0);
  assign out_ch.out_byte   = slot_byte[pos];
  assign out_ch.bad_escape = slot_bad[pos];
  assign out_ch.run_end    = (rem == 2'd1);
  assign out_ch.span_end   = (rem == 2'd1) && slot_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      pos <= 2'd0;
    end else if (load && res.count != 2'd0) begin
      rem <= res.count;
      pos <= 2'd0;
    end else if (take) begin
      rem <= rem - 2'd1;
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_byte <= res.bytes;
      slot_bad  <= res.bad;
      slot_last <= res.last;
    end
  end

endmodule

// ----- sv/percent_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// percent_escape_decoder
// URL-style percent-escape decoder over a valid/ready byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw byte per transaction plus in_last, which marks the
//   final byte of a span. out_ch carries decoded bytes with bad_escape (byte
//   from a malformed or truncated escape), run_end (last byte caused by one
//   input) and span_end (last byte of the span).
//   A '%' that opens an escape, or the first hex digit after it, in mid-span
//   produces nothing and is held; other inputs produce one, two or three bytes.
//   A result is registered and appears on out_ch the cycle after its input is taken.
//   Throughput: one input per cycle while each input yields at most one
//   byte and the receiver is ready; an input yielding several bytes holds the
//   output register until they drain, one byte per cycle while ready.
//   The next input is taken in the cycle the last pending byte leaves, so a
//   stream of plain bytes flows with no bubbles.
//   Reset clears the escape state and empties the output register.
//   When the receiver stalls, the pending byte holds on out_ch and in_ch
//   ready drops until the register can drain.
// ----------------------------------------------------------------------------
module percent_escape_decoder (
  input  logic      clk,
  input  logic      rst,
  ped_in_if.sink    in_ch,
  ped_out_if.source out_ch
);

  ped_pkg::res_t res;
  logic          fire;
  logic          space;

  ped_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .space (space),
    .fire  (fire),
    .res   (res)
  );

  ped_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (fire),
    .res    (res),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

// ----- tb/ped_decode_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ped_decode_monitor
// Watches the raw byte channel and the decoded byte channel of the
// percent-escape decoder. It predicts the output bytes of every input
// transaction and compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module ped_decode_monitor (
  input  logic clk,
  input  logic rst,
  ped_in_if    in_ch,
  ped_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   bytes_checked
);

  typedef struct packed {
    logic [7:0] value;
    logic       bad;
    logic       run_end;
    logic       span_end;
  } out_byte_t;

  ped_pkg::phase_t esc_state;
  logic [7:0]      first_digit;
  out_byte_t       step_bytes[$];
  out_byte_t       expected_bytes[$];

  // Bit 4 flags a hex digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, c[3:0]};
    end
    // 'A'..'F' and 'a'..'f' share the low nibble pattern 1..6
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return 5'd0;
  endfunction

  function automatic void emit(input logic [7:0] value, input logic bad);
    step_bytes.push_back(out_byte_t'{value, bad, 1'b0, 1'b0});
  endfunction

  function automatic void decode_step(input logic [7:0] raw, input logic last);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [7:0] code;
    logic       is_pct;
    out_byte_t  tail;
    lo = hex_digit(raw);
    is_pct = (raw == ped_pkg::CHAR_PCT);
    step_bytes.delete();
    case (esc_state)
      ped_pkg::PH_PCT: begin
        if (last || (!lo[4] && !is_pct)) begin
          emit(ped_pkg::CHAR_PCT, 1'b1);
          emit(raw, 1'b1);
          esc_state = ped_pkg::PH_IDLE;
        end else if (lo[4]) begin
          first_digit = raw;
          esc_state = ped_pkg::PH_DIGIT;
        end else begin
          // a second percent flushes the first and restarts the escape
          emit(ped_pkg::CHAR_PCT, 1'b1);
        end
      end
      ped_pkg::PH_DIGIT: begin
        if (lo[4]) begin
          hi = hex_digit(first_digit);
          code = {hi[3:0], lo[3:0]};
          if (code > ped_pkg::CTRL_MAX && code != ped_pkg::CHAR_DEL &&
              code != ped_pkg::CHAR_COLON) begin
            emit(code, 1'b0);
          end else begin
            // refused value: pass the escape through literally, not flagged
            emit(ped_pkg::CHAR_PCT, 1'b0);
            emit(first_digit, 1'b0);
            emit(raw, 1'b0);
          end
          esc_state = ped_pkg::PH_IDLE;
        end else if (is_pct && !last) begin
          emit(ped_pkg::CHAR_PCT, 1'b1);
          emit(first_digit, 1'b1);
          esc_state = ped_pkg::PH_PCT;
        end else begin
          emit(ped_pkg::CHAR_PCT, 1'b1);
          emit(first_digit, 1'b1);
          emit(raw, 1'b1);
          esc_state = ped_pkg::PH_IDLE;
        end
      end
      default: begin
        if (!is_pct) begin
          emit(raw, 1'b0);
        end else if (last) begin
          emit(ped_pkg::CHAR_PCT, 1'b1);
        end
        esc_state = (is_pct && !last) ? ped_pkg::PH_PCT : ped_pkg::PH_IDLE;
      end
    endcase
    if (last) begin
      esc_state = ped_pkg::PH_IDLE;
      first_digit = '0;
    end
    if (step_bytes.size() > 0) begin
      tail = step_bytes.pop_back();
      tail.run_end = 1'b1;
      tail.span_end = last;
      step_bytes.push_back(tail);
    end
    foreach (step_bytes[i]) begin
      expected_bytes.push_back(step_bytes[i]);
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < 20) begin
      $display("[%0t] decode mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_byte_t got;
    out_byte_t want;
    if (rst) begin
      esc_state = ped_pkg::PH_IDLE;
      first_digit = '0;
      expected_bytes.delete();
      fail_count = 0;
      bytes_checked = 0;
    end else begin
      // drain first: an output transaction never comes from this edge's input
      if (out_ch.valid && out_ch.ready) begin
        got = out_byte_t'{out_ch.out_byte, out_ch.bad_escape, out_ch.run_end,
                          out_ch.span_end};
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing expected", got.value));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (got !== want) begin
            report_mismatch($sformatf(
              "got byte %02h bad %b run %b span %b, want %02h %b %b %b",
              got.value, got.bad, got.run_end, got.span_end,
              want.value, want.bad, want.run_end, want.span_end));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_step(in_ch.in_byte, in_ch.in_last);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives spans of raw bytes into the percent-escape decoder: a directed set of
// escapes, refused values and broken or truncated escapes, then random spans
// that mix well-formed escapes with plain bytes and noise. Both
// sides stall in random bursts, and once the receiver holds off long enough
// to back up the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DIRECTED_ITEMS = 27;
  localparam int RANDOM_ITEMS   = 123;
  localparam int CALM_TAIL      = 30;
  localparam int HOLD_CYCLES    = 120;
  localparam int IDLE_LIMIT     = 2000;

  typedef struct packed {
    logic [7:0] raw;
    logic       last;
  } raw_item_t;

  logic clk;
  logic rst;

  ped_in_if  in_bus ();
  ped_out_if out_bus ();

  int        fail_count;
  int        pending;
  int        bytes_checked;
  raw_item_t stim_q[$];
  int        items_sent   = 0;
  int        spans_sent   = 0;
  int        idle_cycles  = 0;
  bit        calm         = 1'b0;
  bit        squeeze      = 1'b0;
  bit        squeeze_done = 1'b0;

  percent_escape_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  ped_decode_monitor monitor (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_bus),
    .out_ch        (out_bus),
    .fail_count    (fail_count),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void push_raw(input logic [7:0] raw, input logic last);
    stim_q.push_back(raw_item_t'{raw, last});
  endfunction

  function automatic void push_text(input string s, input bit ends_span);
    for (int i = 0; i < s.len(); i++) begin
      push_raw(s[i], ends_span && (i == s.len() - 1));
    end
    if (ends_span) begin
      spans_sent++;
    end
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      return 8'(8'h30 + v);
    end
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  // Well-formed escapes with random digits and plain bytes in equal share, plus noise
  function automatic void push_random_span();
    int        n;
    raw_item_t tail;
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          push_raw(8'($urandom), 1'b0);
        end
        4, 5, 6, 7: begin
          push_raw(ped_pkg::CHAR_PCT, 1'b0);
          push_raw(rand_hex_char(), 1'b0);
          push_raw(rand_hex_char(), 1'b0);
        end
        8: begin
          push_raw(ped_pkg::CHAR_PCT, 1'b0);
          push_raw($urandom_range(0, 3) == 0 ? ped_pkg::CHAR_PCT : 8'($urandom), 1'b0);
        end
        default: begin
          push_raw(ped_pkg::CHAR_PCT, 1'b0);
          push_raw(rand_hex_char(), 1'b0);
          push_raw($urandom_range(0, 3) == 0 ? ped_pkg::CHAR_PCT : 8'($urandom), 1'b0);
        end
      endcase
    end
    tail = stim_q.pop_back();
    tail.last = 1'b1;
    stim_q.push_back(tail);
    spans_sent++;
  endfunction

  // Sender
  initial begin
    rst = 1'b1;
    in_bus.valid = 1'b0;
    in_bus.in_byte = '0;
    in_bus.in_last = 1'b0;

    push_raw(8'h00, 1'b0);
    push_text("%%41", 1'b0);
    push_text("%7f", 1'b0);
    push_text("%3A", 1'b0);
    push_text("%1F", 1'b0);
    push_raw(ped_pkg::CHAR_PCT, 1'b0);
    push_raw(8'hFF, 1'b0);
    push_text("%4z", 1'b0);
    push_text("%4%e", 1'b1);
    push_text("%", 1'b1);
    push_text("%4%", 1'b1);
    while (stim_q.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      push_random_span();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_q[i]) begin
      calm = (stim_q.size() - i) <= CALM_TAIL;
      if (!calm && !squeeze && $urandom_range(0, 3) == 0) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      in_bus.valid   <= 1'b1;
      in_bus.in_byte <= stim_q[i].raw;
      in_bus.in_last <= stim_q[i].last;
      @(posedge clk);
      while (!in_bus.ready) @(posedge clk);
      items_sent++;
    end
    in_bus.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d raw bytes in %0d spans, %0d decoded bytes compared",
             items_sent, spans_sent, bytes_checked);
    $display("including a %0d-cycle output hold-off and a stall-free tail of %0d bytes",
             HOLD_CYCLES, CALM_TAIL);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Receiver
  initial begin
    out_bus.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (calm) begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end else if (!squeeze_done && items_sent >= 60) begin
        // hold off long enough for the decoder to back up its input
        squeeze = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze = 1'b0;
        squeeze_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d bytes still expected",
               idle_cycles, pending);
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
sv/ped_pkg.sv
sv/ped_if.sv
sv/ped_decode.sv
sv/ped_emit.sv
sv/percent_escape_decoder.sv
tb/ped_decode_monitor.sv
tb/testbench.sv
